@@ rtl/ate_pkg.sv @@
// Shared types, sizes and character codes for the text terminal engine.
// Used by every module of the engine except ate_ram; depends on nothing.
package ate_pkg;

  // Screen geometry and parser limits
  localparam int COLUMNS    = 80;
  localparam int ROW_COUNT  = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int MAX_PARAMS = 24;

  localparam int CELLS     = COLUMNS * ROW_COUNT;
  localparam int LAST_LINE = (ROW_COUNT - 1) * COLUMNS;
  localparam int LAST_ROW  = ROW_COUNT - 1;

  localparam int IDX_W   = $clog2(CELLS + 1);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int PCNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int PIDX_W  = $clog2(MAX_PARAMS);
  localparam int PARAM_W = 16;
  localparam int CELL_W  = 16;
  localparam int HPOS_W  = 20;

  localparam logic [7:0]         NORMAL_RST = 8'h07;
  localparam logic [PARAM_W-1:0] PARAM_MAX  = 16'hFFFF;

  // Control characters and other byte codes
  localparam logic [6:0] CH_BEL   = 7'h07;
  localparam logic [6:0] CH_BS    = 7'h08;
  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_ESC   = 7'h1B;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_DEL   = 7'h7F;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_SEMI  = 7'h3B;

  // Command letters
  localparam logic [6:0] LTR_AT  = 7'h40;
  localparam logic [6:0] LTR_A   = 7'h41;
  localparam logic [6:0] LTR_B   = 7'h42;
  localparam logic [6:0] LTR_C   = 7'h43;
  localparam logic [6:0] LTR_G   = 7'h47;
  localparam logic [6:0] LTR_H   = 7'h48;
  localparam logic [6:0] LTR_J   = 7'h4A;
  localparam logic [6:0] LTR_K   = 7'h4B;
  localparam logic [6:0] LTR_L   = 7'h4C;
  localparam logic [6:0] LTR_M   = 7'h4D;
  localparam logic [6:0] LTR_P   = 7'h50;
  localparam logic [6:0] LTR_CSI = 7'h5B;
  localparam logic [6:0] LTR_SGR = 7'h6D;

  typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI, PH_NUM} phase_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SEQ, ST_LOCATE, ST_SGR,
    ST_COPY_RD, ST_COPY_WR, ST_FILL, ST_DONE
  } state_t;

  // Byte class flags computed in the front end
  typedef struct packed {
    logic print;
    logic digit;
    logic semi;
    logic lf;
    logic cr;
    logic bs;
    logic tab;
    logic esc;
    logic bel;
  } cls_t;

  typedef struct packed {
    logic        mode;
    logic [6:0]  ch;
    logic [10:0] read_index;
    logic        last;
    cls_t        cls;
  } item_t;

  function automatic logic [2:0] ansi_to_pc(input logic [2:0] a);
    logic [2:0] r;
    unique case (a)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // One SGR parameter applied to the attribute
  function automatic logic [7:0] sgr_apply(input logic [7:0] attr,
                                           input logic [PARAM_W-1:0] v,
                                           input logic [7:0] normal);
    logic [7:0]         r;
    logic [PARAM_W-1:0] fg;
    logic [PARAM_W-1:0] bg;
    fg = v - PARAM_W'(30);
    bg = v - PARAM_W'(40);
    r  = attr;
    if (v == PARAM_W'(0) || v == PARAM_W'(27)) r = normal;
    else if (v == PARAM_W'(1)) r = attr | 8'h08;
    else if (v == PARAM_W'(5)) r = attr | 8'h80;
    else if (v == PARAM_W'(7)) r = 8'h70;
    else if (v == PARAM_W'(21) || v == PARAM_W'(22)) r = attr & 8'hF7;
    else if (v == PARAM_W'(25)) r = attr & 8'h7F;
    else if (v >= PARAM_W'(30) && v <= PARAM_W'(37))
      r = (attr & 8'hF8) | {5'd0, ansi_to_pc(fg[2:0])};
    else if (v >= PARAM_W'(40) && v <= PARAM_W'(47))
      r = (attr & 8'h8F) | {1'b0, ansi_to_pc(bg[2:0]), 4'd0};
    return r;
  endfunction

endpackage

@@ rtl/ansi_text_terminal_engine_core.sv @@
// Top level of the text terminal engine: front end, request queue and back end.
// Depends on ate_pkg, ate_front, ate_back (which holds ate_ram).
//
//   channel  direction  handshake                fields
//   in       input      in_valid / in_ready      mode, data_byte, read_index, end_of_write
//   out      output     out_valid / out_ready    cell_char, cell_attr, cursor_index,
//                                                current_attr, bell
//   cfg      input      cfg_write                cfg_data (normal attribute)
//
// A plain byte or control code passes through ST_IDLE and ST_DONE, a cell read also through ST_READ.
// Scroll, insert/delete and clear walk the screen memory: each moved cell is read
// and then written (ST_COPY_RD, ST_COPY_WR), and each blanked cell is written in ST_FILL.
// After reset a clearing pass writes all CELLS entries before the
// first request is executed; the queue still accepts up to two requests meanwhile.
// A waiting result stalls the back end only; the front queue keeps accepting until both entries are full.
module ansi_text_terminal_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic [10:0] read_index,
  input  logic        end_of_write,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic [10:0] cursor_index,
  output logic [7:0]  current_attr,
  output logic        bell
);

  logic           q_valid;
  logic           q_pop;
  ate_pkg::item_t q_item;

  ate_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .data_byte    (data_byte),
    .read_index   (read_index),
    .end_of_write (end_of_write),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  ate_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .cursor_index (cursor_index),
    .current_attr (current_attr),
    .bell         (bell)
  );

  // Cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_index < 11'(ate_pkg::CELLS))
    else $error("cursor outside screen");

  // A bell only comes from a fed byte, never with cell data
  a_bell_no_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && bell |-> cell_char == 8'd0 && cell_attr == 8'd0)
    else $error("bell with cell data");

  // Screen cells only ever hold printable characters
  a_cell_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_char != 8'd0 |-> cell_char >= 8'h20 && cell_char < 8'h7F)
    else $error("non-printable character in screen cell");

endmodule

@@ rtl/ate_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ate_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ate_front.sv @@
// Front end: takes requests, classifies the byte, holds them in a 2-entry queue.
// Depends on ate_pkg.
module ate_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [7:0]          data_byte,
  input  logic [10:0]         read_index,
  input  logic                end_of_write,
  output logic                q_valid,
  output ate_pkg::item_t      q_item,
  input  logic                q_pop
);

  ate_pkg::item_t slot [2];
  ate_pkg::item_t new_item;
  logic           wp;
  logic           rp;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  logic [6:0]     c;

  assign c = data_byte[6:0];

  // Classify the byte
  always_comb begin
    new_item.mode       = mode;
    new_item.ch         = c;
    new_item.read_index = read_index;
    new_item.last       = end_of_write;
    new_item.cls.print  = (c >= ate_pkg::CH_SPACE) && (c < ate_pkg::CH_DEL);
    new_item.cls.digit  = (c >= ate_pkg::CH_ZERO) && (c <= ate_pkg::CH_NINE);
    new_item.cls.semi   = (c == ate_pkg::CH_SEMI);
    new_item.cls.lf     = (c == ate_pkg::CH_LF);
    new_item.cls.cr     = (c == ate_pkg::CH_CR);
    new_item.cls.bs     = (c == ate_pkg::CH_BS);
    new_item.cls.tab    = (c == ate_pkg::CH_TAB);
    new_item.cls.esc    = (c == ate_pkg::CH_ESC);
    new_item.cls.bel    = (c == ate_pkg::CH_BEL);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= new_item;
    end
  end

endmodule

@@ rtl/ate_back.sv @@
// Back end: escape parser, cursor, attribute and the screen memory sequencer.
// Depends on ate_pkg and ate_ram.
module ate_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  logic                q_valid,
  input  ate_pkg::item_t      q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          cell_char,
  output logic [7:0]          cell_attr,
  output logic [10:0]         cursor_index,
  output logic [7:0]          current_attr,
  output logic                bell
);

  localparam int IW = ate_pkg::IDX_W;
  localparam int AW = ate_pkg::ADDR_W;
  localparam int RW = ate_pkg::ROW_W;
  localparam int CW = ate_pkg::COL_W;
  localparam int PW = ate_pkg::PARAM_W;
  localparam int NW = ate_pkg::PCNT_W;

  ate_pkg::state_t state, state_next;
  ate_pkg::phase_t phase, phase_next;

  logic [RW-1:0] row, row_next;
  logic [CW-1:0] col, col_next;
  logic [7:0]    attr, attr_next;
  logic [7:0]    normal_attr;
  logic [NW-1:0] pcount, pcount_next;
  logic [PW-1:0] acc, acc_next;
  logic [PW-1:0] pstore [ate_pkg::MAX_PARAMS];
  logic          pst_we;
  logic [6:0]    seq_c, seq_c_next;
  logic [NW-1:0] seq_n, seq_n_next;
  logic [IW-1:0] cp_dst, cp_dst_next;
  logic [IW-1:0] cp_d, cp_d_next;
  logic [IW-1:0] cp_cnt, cp_cnt_next;
  logic          cp_up, cp_up_next;
  logic [IW-1:0] fl_addr, fl_addr_next;
  logic [IW-1:0] fl_cnt, fl_cnt_next;
  logic [IW-1:0] loc_rem, loc_rem_next;
  logic [ate_pkg::PIDX_W-1:0] sgr_i, sgr_i_next;
  logic [7:0]    res_char, res_char_next;
  logic [7:0]    res_attr, res_attr_next;
  logic          res_bell, res_bell_next;
  logic          out_load;

  // Memory port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ate_pkg::CELL_W-1:0]   ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [ate_pkg::CELL_W-1:0]   ram_rdata;

  // Cursor arithmetic
  logic [IW-1:0] row_base;
  logic [IW-1:0] cur;
  logic [IW-1:0] row_end;
  logic [IW-1:0] rem;
  logic          at_last_row;
  logic [IW-1:0] src;
  logic [IW-1:0] tsum;
  logic [19:0]   prod;
  logic [3:0]    dval;

  // Sequence arguments
  logic [PW-1:0] x_raw;
  logic [PW-1:0] seq_y;
  logic [IW-1:0] x_i;
  logic [IW-1:0] rows_left;
  logic [IW-1:0] krow;
  logic [IW-1:0] kc;
  logic [IW-1:0] kcol;
  logic [IW-1:0] up_amt;
  logic [IW-1:0] dn_amt;
  logic [IW-1:0] csum;
  logic [ate_pkg::HPOS_W-1:0] hsum;

  logic do_scroll;

  ate_ram #(.WIDTH(ate_pkg::CELL_W), .DEPTH(ate_pkg::CELLS)) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign row_base    = IW'(32'(row) * ate_pkg::COLUMNS);
  assign cur         = row_base + IW'(col);
  assign row_end     = row_base + IW'(ate_pkg::COLUMNS);
  assign rem         = IW'(ate_pkg::COLUMNS) - IW'(col);
  assign at_last_row = (row == RW'(ate_pkg::LAST_ROW));
  assign src         = cp_up ? (cp_dst + cp_d) : (cp_dst - cp_d);
  assign tsum        = IW'(col) + IW'(ate_pkg::TAB_WIDTH)
                     - (IW'(col) % IW'(ate_pkg::TAB_WIDTH));
  assign dval        = q_item.ch[3:0];
  assign prod        = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, dval};

  assign x_raw     = (seq_n == NW'(1) || seq_n == NW'(2)) ? pstore[0] : PW'(1);
  assign seq_y     = (seq_n == NW'(2)) ? pstore[1] : PW'(1);
  assign x_i       = (x_raw > PW'(ate_pkg::COLUMNS)) ? IW'(ate_pkg::COLUMNS) : IW'(x_raw);
  assign rows_left = IW'(ate_pkg::ROW_COUNT) - IW'(row);
  assign krow      = (x_i < rows_left) ? x_i : rows_left;
  assign kc        = IW'(32'(krow) * ate_pkg::COLUMNS);
  assign kcol      = (x_i < rem) ? x_i : rem;
  assign up_amt    = (x_i < IW'(row)) ? x_i : IW'(row);
  assign dn_amt    = (x_i < IW'(ate_pkg::LAST_ROW) - IW'(row)) ? x_i
                   : IW'(ate_pkg::LAST_ROW) - IW'(row);
  assign csum      = IW'(col) + x_i;
  assign hsum      = ate_pkg::HPOS_W'(32'(x_i) * ate_pkg::COLUMNS)
                   + ate_pkg::HPOS_W'(seq_y);

  // State register and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ate_pkg::ST_CLEAR;
      phase       <= ate_pkg::PH_TEXT;
      row         <= '0;
      col         <= '0;
      attr        <= ate_pkg::NORMAL_RST;
      normal_attr <= ate_pkg::NORMAL_RST;
      pcount      <= '0;
      fl_addr     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      row       <= row_next;
      col       <= col_next;
      attr      <= attr_next;
      pcount    <= pcount_next;
      fl_addr   <= fl_addr_next;
      out_valid <= out_load | (out_valid & ~out_ready);
      if (cfg_write) normal_attr <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc      <= acc_next;
    seq_c    <= seq_c_next;
    seq_n    <= seq_n_next;
    cp_dst   <= cp_dst_next;
    cp_d     <= cp_d_next;
    cp_cnt   <= cp_cnt_next;
    cp_up    <= cp_up_next;
    fl_cnt   <= fl_cnt_next;
    loc_rem  <= loc_rem_next;
    sgr_i    <= sgr_i_next;
    res_char <= res_char_next;
    res_attr <= res_attr_next;
    res_bell <= res_bell_next;
    if (pst_we) pstore[pcount[ate_pkg::PIDX_W-1:0]] <= acc;
    if (out_load) begin
      cell_char    <= res_char;
      cell_attr    <= res_attr;
      cursor_index <= 11'(cur);
      current_attr <= attr;
      bell         <= res_bell;
    end
  end

  // Next state and sequencer actions
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    row_next      = row;
    col_next      = col;
    attr_next     = attr;
    pcount_next   = pcount;
    acc_next      = acc;
    seq_c_next    = seq_c;
    seq_n_next    = seq_n;
    cp_dst_next   = cp_dst;
    cp_d_next     = cp_d;
    cp_cnt_next   = cp_cnt;
    cp_up_next    = cp_up;
    fl_addr_next  = fl_addr;
    fl_cnt_next   = fl_cnt;
    loc_rem_next  = loc_rem;
    sgr_i_next    = sgr_i;
    res_char_next = res_char;
    res_attr_next = res_attr;
    res_bell_next = res_bell;
    pst_we        = 1'b0;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    do_scroll     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = AW'(fl_addr);
    ram_wdata     = {attr, 1'b0, ate_pkg::CH_SPACE};
    ram_raddr     = AW'(src);

    unique case (state)
      // Blank the whole screen after reset
      ate_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        fl_addr_next = fl_addr + IW'(1);
        if (fl_addr == IW'(ate_pkg::CELLS - 1)) state_next = ate_pkg::ST_IDLE;
      end

      // Take a request from the queue and dispatch it
      ate_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          res_char_next = 8'd0;
          res_attr_next = 8'd0;
          res_bell_next = 1'b0;
          state_next    = ate_pkg::ST_DONE;
          if (q_item.mode) begin
            ram_raddr = AW'(q_item.read_index);
            if (32'(q_item.read_index) < ate_pkg::CELLS) state_next = ate_pkg::ST_READ;
          end else begin
            unique case (phase)
              ate_pkg::PH_ESC: begin
                phase_next = ate_pkg::PH_TEXT;
                priority case (q_item.ch)
                  ate_pkg::LTR_P: if (!at_last_row) row_next = row + RW'(1);
                  ate_pkg::LTR_K: begin
                    if (col != '0) col_next = col - CW'(1);
                    else if (row != '0) begin
                      row_next = row - RW'(1);
                      col_next = CW'(ate_pkg::COLUMNS - 1);
                    end
                  end
                  ate_pkg::LTR_H: if (row != '0) row_next = row - RW'(1);
                  ate_pkg::LTR_M: begin
                    if (col != CW'(ate_pkg::COLUMNS - 1)) col_next = col + CW'(1);
                    else if (!at_last_row) begin
                      col_next = '0;
                      row_next = row + RW'(1);
                    end
                  end
                  ate_pkg::LTR_G: begin
                    row_next = '0;
                    col_next = '0;
                  end
                  ate_pkg::LTR_CSI: begin
                    pcount_next = '0;
                    acc_next    = '0;
                    phase_next  = ate_pkg::PH_CSI;
                  end
                  default: ;
                endcase
              end
              ate_pkg::PH_CSI: begin
                if (q_item.cls.digit) begin
                  acc_next   = PW'(dval);
                  phase_next = ate_pkg::PH_NUM;
                end else begin
                  seq_n_next = '0;
                  seq_c_next = q_item.ch;
                  phase_next = ate_pkg::PH_TEXT;
                  state_next = ate_pkg::ST_SEQ;
                end
              end
              ate_pkg::PH_NUM: begin
                if (q_item.cls.semi) begin
                  pst_we      = 1'b1;
                  pcount_next = pcount + NW'(1);
                  if (32'(pcount) + 1 < ate_pkg::MAX_PARAMS) acc_next = '0;
                  else phase_next = ate_pkg::PH_TEXT;
                end else if (q_item.cls.digit) begin
                  acc_next = (prod > 20'(ate_pkg::PARAM_MAX)) ? ate_pkg::PARAM_MAX
                                                              : PW'(prod);
                end else begin
                  pst_we      = 1'b1;
                  pcount_next = pcount + NW'(1);
                  seq_n_next  = pcount + NW'(1);
                  seq_c_next  = q_item.ch;
                  phase_next  = ate_pkg::PH_TEXT;
                  state_next  = ate_pkg::ST_SEQ;
                end
              end
              default: begin
                // Plain text
                if (q_item.cls.print) begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(cur);
                  ram_wdata = {attr, 1'b0, q_item.ch};
                  if (col == CW'(ate_pkg::COLUMNS - 1)) begin
                    col_next = '0;
                    if (at_last_row) do_scroll = 1'b1;
                    else row_next = row + RW'(1);
                  end else begin
                    col_next = col + CW'(1);
                  end
                end else if (q_item.cls.lf) begin
                  col_next = '0;
                  if (at_last_row) do_scroll = 1'b1;
                  else row_next = row + RW'(1);
                end else if (q_item.cls.cr) begin
                  col_next = '0;
                end else if (q_item.cls.bs) begin
                  if (col != '0) col_next = col - CW'(1);
                  else if (row != '0) begin
                    row_next = row - RW'(1);
                    col_next = CW'(ate_pkg::COLUMNS - 1);
                  end
                end else if (q_item.cls.tab) begin
                  if (tsum >= IW'(ate_pkg::COLUMNS)) begin
                    if (at_last_row) begin
                      do_scroll = 1'b1;
                      col_next  = '0;
                    end else begin
                      row_next = row + RW'(1);
                      col_next = CW'(tsum - IW'(ate_pkg::COLUMNS));
                    end
                  end else begin
                    col_next = CW'(tsum);
                  end
                end else if (q_item.cls.esc) begin
                  phase_next = ate_pkg::PH_ESC;
                end else if (q_item.cls.bel) begin
                  res_bell_next = 1'b1;
                end
              end
            endcase
          end
        end
      end

      // Cell read data is back from the memory
      ate_pkg::ST_READ: begin
        res_char_next = ram_rdata[7:0];
        res_attr_next = ram_rdata[15:8];
        state_next    = ate_pkg::ST_DONE;
      end

      // Run a CSI sequence
      ate_pkg::ST_SEQ: begin
        state_next  = ate_pkg::ST_DONE;
        cp_cnt_next = '0;
        fl_cnt_next = '0;
        priority case (seq_c)
          ate_pkg::LTR_A: row_next = row - RW'(up_amt);
          ate_pkg::LTR_B: row_next = row + RW'(dn_amt);
          ate_pkg::LTR_C: begin
            if (csum >= IW'(ate_pkg::COLUMNS)) begin
              if (at_last_row) col_next = CW'(ate_pkg::COLUMNS - 1);
              else begin
                row_next = row + RW'(1);
                col_next = CW'(csum - IW'(ate_pkg::COLUMNS));
              end
            end else begin
              col_next = CW'(csum);
            end
          end
          ate_pkg::LTR_L: begin
            cp_dst_next  = IW'(ate_pkg::CELLS - 1);
            cp_d_next    = kc;
            cp_cnt_next  = IW'(ate_pkg::CELLS) - row_base - kc;
            cp_up_next   = 1'b0;
            fl_addr_next = row_base;
            fl_cnt_next  = kc;
            state_next   = ate_pkg::ST_COPY_RD;
          end
          ate_pkg::LTR_M: begin
            cp_dst_next  = row_base;
            cp_d_next    = kc;
            cp_cnt_next  = IW'(ate_pkg::CELLS) - row_base - kc;
            cp_up_next   = 1'b1;
            fl_addr_next = IW'(ate_pkg::CELLS) - kc;
            fl_cnt_next  = kc;
            state_next   = ate_pkg::ST_COPY_RD;
          end
          ate_pkg::LTR_AT: begin
            cp_dst_next  = row_end - IW'(1);
            cp_d_next    = kcol;
            cp_cnt_next  = rem - kcol;
            cp_up_next   = 1'b0;
            fl_addr_next = cur;
            fl_cnt_next  = kcol;
            state_next   = ate_pkg::ST_COPY_RD;
          end
          ate_pkg::LTR_P: begin
            cp_dst_next  = cur;
            cp_d_next    = kcol;
            cp_cnt_next  = rem - kcol;
            cp_up_next   = 1'b1;
            fl_addr_next = row_end - kcol;
            fl_cnt_next  = kcol;
            state_next   = ate_pkg::ST_COPY_RD;
          end
          ate_pkg::LTR_J: begin
            if (x_i == IW'(1)) begin
              fl_addr_next = cur;
              fl_cnt_next  = IW'(ate_pkg::CELLS) - cur;
            end else begin
              fl_addr_next = '0;
              fl_cnt_next  = IW'(ate_pkg::CELLS);
              row_next     = '0;
              col_next     = '0;
            end
            state_next = ate_pkg::ST_FILL;
          end
          ate_pkg::LTR_K: begin
            fl_addr_next = cur;
            fl_cnt_next  = rem;
            state_next   = ate_pkg::ST_FILL;
          end
          ate_pkg::LTR_H: begin
            // Position before the screen homes, past the end goes to the last line
            if (hsum < ate_pkg::HPOS_W'(ate_pkg::COLUMNS + 1)) begin
              row_next = '0;
              col_next = '0;
            end else if (hsum >= ate_pkg::HPOS_W'(ate_pkg::CELLS + ate_pkg::COLUMNS + 1)) begin
              row_next = RW'(ate_pkg::LAST_ROW);
              col_next = '0;
            end else begin
              row_next     = '0;
              loc_rem_next = IW'(hsum - ate_pkg::HPOS_W'(ate_pkg::COLUMNS + 1));
              state_next   = ate_pkg::ST_LOCATE;
            end
          end
          ate_pkg::LTR_SGR: begin
            if (seq_n == '0) attr_next = normal_attr;
            else begin
              sgr_i_next = '0;
              state_next = ate_pkg::ST_SGR;
            end
          end
          default: ;
        endcase
      end

      // Split a cell index into row and column, one row per cycle
      ate_pkg::ST_LOCATE: begin
        if (loc_rem >= IW'(ate_pkg::COLUMNS)) begin
          loc_rem_next = loc_rem - IW'(ate_pkg::COLUMNS);
          row_next     = row + RW'(1);
        end else begin
          col_next   = CW'(loc_rem);
          state_next = ate_pkg::ST_DONE;
        end
      end

      // One SGR parameter per cycle
      ate_pkg::ST_SGR: begin
        attr_next  = ate_pkg::sgr_apply(attr, pstore[sgr_i], normal_attr);
        sgr_i_next = sgr_i + ate_pkg::PIDX_W'(1);
        if (NW'(sgr_i) + NW'(1) == seq_n) state_next = ate_pkg::ST_DONE;
      end

      // Block move: read the source cell
      ate_pkg::ST_COPY_RD: begin
        ram_raddr = AW'(src);
        if (cp_cnt == '0) state_next = ate_pkg::ST_FILL;
        else state_next = ate_pkg::ST_COPY_WR;
      end

      // Block move: write it to the destination
      ate_pkg::ST_COPY_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = AW'(cp_dst);
        ram_wdata   = ram_rdata;
        cp_dst_next = cp_up ? (cp_dst + IW'(1)) : (cp_dst - IW'(1));
        cp_cnt_next = cp_cnt - IW'(1);
        state_next  = ate_pkg::ST_COPY_RD;
      end

      // Blank a run of cells
      ate_pkg::ST_FILL: begin
        if (fl_cnt == '0) state_next = ate_pkg::ST_DONE;
        else begin
          ram_we       = 1'b1;
          fl_addr_next = fl_addr + IW'(1);
          fl_cnt_next  = fl_cnt - IW'(1);
        end
      end

      // Hand the result to the output register
      ate_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ate_pkg::ST_IDLE;
        end
      end

      default: state_next = ate_pkg::ST_IDLE;
    endcase

    // Scroll up one line and blank the last one
    if (do_scroll) begin
      cp_dst_next  = '0;
      cp_d_next    = IW'(ate_pkg::COLUMNS);
      cp_cnt_next  = IW'(ate_pkg::LAST_LINE);
      cp_up_next   = 1'b1;
      fl_addr_next = IW'(ate_pkg::LAST_LINE);
      fl_cnt_next  = IW'(ate_pkg::COLUMNS);
      state_next   = ate_pkg::ST_COPY_RD;
    end
  end

endmodule
